// ----- sv/assert_macros.svh -----
// Assertion macros used by the top level of the sprite row decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle, disabled while reset is low.
`define RSRD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsrd assertion failed");

// Consequent checked in the cycle after the antecedent.
`define RSRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsrd assertion failed");

`endif

// ----- sv/rsrd_pkg.sv -----
// Types, constants and register codes of the sprite row decoder.
package rsrd_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [7:0]  CTRL_ROW_END  = 8'h80;
    localparam logic [7:0]  CTRL_RUN_MASK = 8'h7F;
    localparam logic [11:0] ROW_OFF       = 12'hFFF;
    localparam logic [10:0] COL_MAX       = 11'd2047;

    localparam logic [1:0] CFG_IDX_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_IDX_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_IDX_ENCODED_LENGTH = 2'd2;

    typedef enum logic [3:0] {
        PH_SKIP = 4'b0001,
        PH_CTRL = 4'b0010,
        PH_LIT  = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [23:0] encoded_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic        pixel_valid;
        logic [19:0] pixel_addr;
        logic [7:0]  pixel_value;
        logic        frame_done;
        logic        format_error;
    } t_out_item;

    // Request handed from the front to the back: position of the write and flags.
    typedef struct packed {
        logic        pixel_valid;
        logic [10:0] column;
        logic [11:0] row;
        logic [7:0]  pixel_value;
        logic        frame_done;
        logic        format_error;
    } t_cmd;

endpackage

// ----- sv/rsrd_queue.sv -----
// Small register queue used between the decoder stages and at the result side.
module rsrd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rsrd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ----- sv/rsrd_front.sv -----
// Front of the decoder: parses control and literal bytes and tracks position.
module rsrd_front #(
    parameter int MAX_WIDTH  = rsrd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rsrd_pkg::DEF_MAX_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsrd_pkg::t_cfg     i_cfg,
    input  logic               i_accept,
    input  rsrd_pkg::t_in_item i_item,
    output logic               o_cmd_valid,
    output rsrd_pkg::t_cmd     o_cmd
);
    rsrd_pkg::t_phase r_phase, n_phase;
    logic [6:0]       r_lit, n_lit;
    logic [10:0]      r_col, n_col;
    logic [11:0]      r_row, n_row;
    logic [23:0]      r_cnt, n_cnt;
    logic             r_err, n_err;

    always_comb begin
        logic        proceed;
        logic        done_now;
        logic        ok;
        logic [11:0] col_sum;
        logic [7:0]  b;

        b       = i_item.data_byte;
        n_phase = r_phase;
        n_lit   = r_lit;
        n_col   = r_col;
        n_row   = r_row;
        n_cnt   = r_cnt;
        n_err   = r_err;
        proceed  = 1'b0;
        done_now = 1'b0;
        ok       = 1'b0;
        col_sum  = '0;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;

        if (i_item.frame_start) begin
            n_phase = rsrd_pkg::PH_SKIP;
            n_lit   = '0;
            n_col   = '0;
            n_row   = {1'b0, i_cfg.frame_height} - 12'd1;
            n_cnt   = '0;
            n_err   = 1'b0;
        end

        unique case (n_phase) inside
            rsrd_pkg::PH_SKIP: begin
                if (b != 8'd0) begin
                    if (n_cnt >= i_cfg.encoded_length) begin
                        // Empty frame: end it on the first nonzero byte, uncounted.
                        n_phase = rsrd_pkg::PH_DONE;
                        o_cmd_valid      = 1'b1;
                        o_cmd.frame_done = 1'b1;
                    end else begin
                        n_phase = rsrd_pkg::PH_CTRL;
                        proceed = 1'b1;
                    end
                end
            end
            rsrd_pkg::PH_CTRL, rsrd_pkg::PH_LIT: proceed = 1'b1;
            rsrd_pkg::PH_DONE: ;
            default: ;
        endcase

        if (proceed) begin
            n_cnt    = n_cnt + 24'd1;
            done_now = (n_cnt >= i_cfg.encoded_length);
            if (n_phase == rsrd_pkg::PH_LIT) begin
                ok = (n_col < i_cfg.frame_width) && (n_row < {1'b0, i_cfg.frame_height})
                    && (32'(i_cfg.frame_width) <= 32'(MAX_WIDTH))
                    && (32'(i_cfg.frame_height) <= 32'(MAX_HEIGHT));
                if (!ok) begin
                    n_err = 1'b1;
                end
                o_cmd.pixel_valid = ok;
                o_cmd.column      = n_col;
                o_cmd.row         = n_row;
                o_cmd.pixel_value = ok ? b : 8'd0;
                if (n_col < rsrd_pkg::COL_MAX) begin
                    n_col = n_col + 11'd1;
                end
                n_lit = n_lit - 7'd1;
                if (n_lit == 7'd0) begin
                    n_phase = rsrd_pkg::PH_CTRL;
                end
                o_cmd_valid = 1'b1;
            end else begin
                if (b == rsrd_pkg::CTRL_ROW_END) begin
                    n_col = '0;
                    if (n_row != rsrd_pkg::ROW_OFF) begin
                        n_row = (n_row == 12'd0) ? rsrd_pkg::ROW_OFF : n_row - 12'd1;
                    end
                end else if (b[7]) begin
                    col_sum = {1'b0, n_col} + 12'(b & rsrd_pkg::CTRL_RUN_MASK);
                    n_col   = (col_sum > {1'b0, rsrd_pkg::COL_MAX}) ? rsrd_pkg::COL_MAX
                                                                    : col_sum[10:0];
                end else if (b != 8'd0) begin
                    n_lit   = b[6:0];
                    n_phase = rsrd_pkg::PH_LIT;
                end
                o_cmd_valid = done_now;
            end
            if (done_now) begin
                n_phase = rsrd_pkg::PH_DONE;
            end
            o_cmd.frame_done = done_now;
        end
        o_cmd.format_error = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rsrd_pkg::PH_SKIP;
            r_lit   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_cnt   <= '0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_lit   <= n_lit;
            r_col   <= n_col;
            r_row   <= n_row;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
        end
    end
endmodule

// ----- sv/rsrd_back.sv -----
// Back of the decoder: forms the linear pixel address from column and row.
module rsrd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [10:0]         i_frame_width,
    input  rsrd_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_empty,
    output logic                o_cmd_pop,
    output logic                o_out_push,
    output rsrd_pkg::t_out_item o_out,
    input  logic                i_out_full
);
    logic           r_valid;
    logic [22:0]    r_prod;
    rsrd_pkg::t_cmd r_cmd;
    logic           w_adv;
    logic [23:0]    w_sum;

    // The stage moves on when it is empty or its result goes into the result queue.
    assign w_adv      = !r_valid || !i_out_full;
    assign o_cmd_pop  = w_adv && !i_cmd_empty;
    assign o_out_push = r_valid && !i_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= !i_cmd_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod <= 23'(i_frame_width) * 23'(i_cmd.row);
            r_cmd  <= i_cmd;
        end
    end

    assign w_sum = {1'b0, r_prod} + 24'(r_cmd.column);

    always_comb begin
        o_out.pixel_valid  = r_cmd.pixel_valid;
        o_out.pixel_addr   = r_cmd.pixel_valid ? w_sum[19:0] : 20'd0;
        o_out.pixel_value  = r_cmd.pixel_value;
        o_out.frame_done   = r_cmd.frame_done;
        o_out.format_error = r_cmd.format_error;
    end
endmodule

// ----- sv/rle_sprite_row_decoder_core.sv -----
// Top level of the run-length sprite row decoder: config registers, stages and queues.
//
//  channel   direction  handshake                 payload
//  input     in         push / full               i_in  (data_byte, frame_start)
//  result    out        empty / pop               o_out (pixel and status fields)
//  config    in         i_cfg_we, i_cfg_idx       i_cfg_data (24 bits)
//
// One byte is taken every cycle while full is low; the front updates position and
// counters in that cycle, and the back adds a multiply register and the result queue.
// A result goes through the request queue, multiply register and result queue.
// Reset is synchronous and clears the front state and both queues; no clearing pass.
// full rises only when the request queue backs up behind a stalled result side.
`include "assert_macros.svh"

module rle_sprite_row_decoder_core #(
    parameter int MAX_WIDTH   = rsrd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = rsrd_pkg::DEF_MAX_HEIGHT,
    parameter int QUEUE_DEPTH = rsrd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  rsrd_pkg::t_in_item  i_in,
    output logic                empty,
    input  logic                pop,
    output rsrd_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_data
);
    localparam int CMD_W = $bits(rsrd_pkg::t_cmd);
    localparam int OUT_W = $bits(rsrd_pkg::t_out_item);

    rsrd_pkg::t_cfg      r_cfg;
    logic                w_accept;
    logic                w_cmd_valid;
    rsrd_pkg::t_cmd      w_cmd_in, w_cmd_out;
    logic                w_cmd_full, w_cmd_empty, w_cmd_pop;
    logic                w_out_push, w_out_full;
    rsrd_pkg::t_out_item w_out_in;
    logic                w_blank_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width    <= 11'd1;
            r_cfg.frame_height   <= 11'd1;
            r_cfg.encoded_length <= 24'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rsrd_pkg::CFG_IDX_FRAME_WIDTH:    r_cfg.frame_width    <= i_cfg_data[10:0];
                rsrd_pkg::CFG_IDX_FRAME_HEIGHT:   r_cfg.frame_height   <= i_cfg_data[10:0];
                rsrd_pkg::CFG_IDX_ENCODED_LENGTH: r_cfg.encoded_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full     = w_cmd_full;
    assign w_accept = push && !w_cmd_full;

    rsrd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (w_accept),
        .i_item      (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd_in)
    );

    rsrd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && w_cmd_valid),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    rsrd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_width (r_cfg.frame_width),
        .i_cmd         (w_cmd_out),
        .i_cmd_empty   (w_cmd_empty),
        .o_cmd_pop     (w_cmd_pop),
        .o_out_push    (w_out_push),
        .o_out         (w_out_in),
        .i_out_full    (w_out_full)
    );

    rsrd_queue #(
        .WIDTH (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_in),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );

    assign w_blank_ok = (o_out.pixel_addr == 20'd0) && (o_out.pixel_value == 8'd0);

    // A result without a pixel write carries zero address and value.
    `RSRD_ASSERT_SAME(a_blank_result, i_clk, i_rst_n, !empty && !o_out.pixel_valid, w_blank_ok)
    // The back only takes a request when one is waiting.
    `RSRD_ASSERT_SAME(a_cmd_pop_ok, i_clk, i_rst_n, w_cmd_pop, !w_cmd_empty)
    // A request pushed into an empty request queue is visible next cycle.
    `RSRD_ASSERT_NEXT(a_cmd_arrives, i_clk, i_rst_n, w_accept && w_cmd_valid, !w_cmd_empty)

endmodule
